// ===== rtl/core/stng_pkg.sv =====
package stng_pkg;

	// Fixed field widths
	localparam int STEP_W   = 32;
	localparam int DUR_W    = 16;
	localparam int CNT_W    = 22;
	localparam int AMP_W    = 15;
	localparam int SINE_W   = 15;
	localparam int SAMPLE_W = 16;

	// Audio rate and sine table size
	localparam int SAMPLE_RATE = 44100;
	localparam int TABLE_BITS  = 10;
	localparam int QUARTER     = 1 << (TABLE_BITS - 2);
	localparam int ADDR_W      = TABLE_BITS - 1;

	// Longest note in samples
	localparam int LEFT_MAX = (1 << CNT_W) - 1;

	// Peak level after reset
	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(28000);

	// Depth of the queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Pi/2 in Q30
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// Taylor divisors 2n(2n+1) as reciprocals, exact for products below 2^63
	localparam int TAYLOR_SHIFT = 72;
	localparam int WIDE_W       = TAYLOR_SHIFT + 64;
	typedef logic [TAYLOR_SHIFT-1:0] taylor_recip_t [6];
	localparam taylor_recip_t TAYLOR_RECIP = '{
		TAYLOR_SHIFT'(((73'd1 << TAYLOR_SHIFT) + 73'd5) / 73'd6),
		TAYLOR_SHIFT'(((73'd1 << TAYLOR_SHIFT) + 73'd19) / 73'd20),
		TAYLOR_SHIFT'(((73'd1 << TAYLOR_SHIFT) + 73'd41) / 73'd42),
		TAYLOR_SHIFT'(((73'd1 << TAYLOR_SHIFT) + 73'd71) / 73'd72),
		TAYLOR_SHIFT'(((73'd1 << TAYLOR_SHIFT) + 73'd109) / 73'd110),
		TAYLOR_SHIFT'(((73'd1 << TAYLOR_SHIFT) + 73'd155) / 73'd156)
	};

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	// Word handed from front to back
	typedef struct packed {
		func_t             func;
		logic [STEP_W-1:0] step;
		logic [CNT_W-1:0]  count;
	} item_t;

	typedef logic [SINE_W-1:0] sine_tab_t [QUARTER+1];

	// Quarter-wave entry k in Q15: Q30 Taylor series through x^13, rounded half up
	function automatic logic [SINE_W-1:0] sine_entry(int unsigned k);
		longint            x;
		longint            x2;
		longint            term;
		longint            sum;
		longint            r;
		logic [WIDE_W-1:0] wide;
		x    = (HALF_PI_Q30 * longint'(k)) >>> (TABLE_BITS - 2);
		x2   = (x * x) >>> 30;
		term = x;
		sum  = x;
		for (int n = 1; n <= 6; n++) begin
			wide = WIDE_W'(term * x2) * WIDE_W'(TAYLOR_RECIP[n-1]);
			term = longint'(wide >> TAYLOR_SHIFT);
			term = term >>> 30;
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (sum + 64'sd16384) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end
		return r[SINE_W-1:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		for (int k = 0; k <= QUARTER; k++) begin
			tab[k] = sine_entry(k);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/core/stng_front.sv =====
module stng_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  stng_pkg::func_t               in_func,
	input  logic [stng_pkg::STEP_W-1:0]   in_step,
	input  logic [stng_pkg::DUR_W-1:0]    in_dur,
	output logic                          push,
	output stng_pkg::item_t               item,
	input  logic                          q_full
);

	// Split the rate into whole kilohertz and a remainder below 1000
	localparam int SR_INT  = stng_pkg::SAMPLE_RATE / 1000;
	localparam int SR_FRAC = stng_pkg::SAMPLE_RATE % 1000;
	localparam int SR_INT_W = $clog2(SR_INT + 1);
	localparam int INT_W   = stng_pkg::DUR_W + SR_INT_W;
	localparam int FRAC_W  = stng_pkg::DUR_W + 10;
	localparam int SUM_W   = INT_W + 1;
	localparam int CMP_W   = (SUM_W > stng_pkg::CNT_W) ? SUM_W : stng_pkg::CNT_W;
	// floor(x / 1000) as (x * RECIP) >> RECIP_SHIFT, exact for x below 2^FRAC_W
	localparam int RECIP_SHIFT = FRAC_W + 11;
	localparam int RECIP_W     = RECIP_SHIFT - 9;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);
	localparam logic [SR_INT_W-1:0] SR_INT_C = SR_INT_W'(SR_INT);
	localparam logic [9:0] SR_FRAC_C = 10'(SR_FRAC);

	logic                          en;
	logic                          v_s1;
	stng_pkg::func_t               func_s1;
	logic [stng_pkg::STEP_W-1:0]   step_s1;
	logic [INT_W-1:0]              int_s1;
	logic [FRAC_W-1:0]             frac_s1;
	logic                          v_s2;
	stng_pkg::func_t               func_s2;
	logic [stng_pkg::STEP_W-1:0]   step_s2;
	logic [INT_W-1:0]              int_s2;
	logic [stng_pkg::DUR_W-1:0]    quot_s2;
	logic [FRAC_W+RECIP_W-1:0]     recip_prod;
	logic [SUM_W-1:0]              sum;
	logic [CMP_W-1:0]              sum_ext;

	// Advance the whole pipe unless its last word is blocked by a full queue
	assign en       = !v_s2 || !q_full;
	assign in_ready = en;
	assign push     = v_s2 && !q_full;

	// Stage 1: scale the duration by both parts of the rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= in_func;
			step_s1 <= in_step;
			int_s1  <= {{(INT_W-stng_pkg::DUR_W){1'b0}}, in_dur} *
				{{(INT_W-SR_INT_W){1'b0}}, SR_INT_C};
			frac_s1 <= {10'b0, in_dur} * {{(FRAC_W-10){1'b0}}, SR_FRAC_C};
		end
	end

	// Stage 2: divide the remainder product by 1000
	assign recip_prod = {{RECIP_W{1'b0}}, frac_s1} * {{FRAC_W{1'b0}}, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			step_s2 <= step_s1;
			int_s2  <= int_s1;
			quot_s2 <= recip_prod[RECIP_SHIFT +: stng_pkg::DUR_W];
		end
	end

	// Sum the parts and saturate the sample count; ticks carry zero step and count
	assign sum     = {1'b0, int_s2} + {{(SUM_W-stng_pkg::DUR_W){1'b0}}, quot_s2};
	assign sum_ext = CMP_W'(sum);

	always_comb begin
		item.func = func_s2;
		if (func_s2 == stng_pkg::FUNC_LOAD) begin
			item.step = step_s2;
			if (sum_ext > CMP_W'(stng_pkg::LEFT_MAX)) begin
				item.count = stng_pkg::CNT_W'(stng_pkg::LEFT_MAX);
			end else begin
				item.count = sum_ext[stng_pkg::CNT_W-1:0];
			end
		end else begin
			item.step  = '0;
			item.count = '0;
		end
	end

endmodule

// ===== rtl/core/stng_queue.sv =====
module stng_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stng_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output stng_pkg::item_t rd_item,
	output logic            empty
);

	stng_pkg::item_t                 mem [stng_pkg::QDEPTH];
	logic [stng_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [stng_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [stng_pkg::QCNT_W-1:0]     cnt_q;

	assign full    = (cnt_q == stng_pkg::QCNT_W'(stng_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem[rd_ptr_q];

	// Store the word at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/stng_back.sv =====
module stng_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [stng_pkg::AMP_W-1:0]      cfg_wdata,
	input  stng_pkg::item_t                 q_item,
	input  logic                            q_empty,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [stng_pkg::SAMPLE_W-1:0]   out_sample,
	output logic                            out_last
);

	logic [stng_pkg::AMP_W-1:0]      amp_q;
	logic [stng_pkg::STEP_W-1:0]     phase_q;
	logic [stng_pkg::STEP_W-1:0]     step_q;
	logic [stng_pkg::CNT_W-1:0]      left_q;
	logic                            en;
	logic                            emit;
	logic [stng_pkg::TABLE_BITS-1:0] idx;
	logic [stng_pkg::ADDR_W-1:0]     k_ext;
	logic [stng_pkg::ADDR_W-1:0]     addr;
	logic                            v_s1;
	logic [stng_pkg::SINE_W-1:0]     mag_s1;
	logic                            neg_s1;
	logic                            last_s1;
	logic [2*stng_pkg::AMP_W-1:0]    prod;
	logic [stng_pkg::SAMPLE_W-1:0]   scaled;
	logic                            out_valid_q;
	logic [stng_pkg::SAMPLE_W-1:0]   sample_q;
	logic                            last_q;

	assign out_valid  = out_valid_q;
	assign out_sample = sample_q;
	assign out_last   = last_q;

	// Move the back pipe whenever the output register is free or drained
	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && !q_empty;
	assign emit  = q_pop && (q_item.func == stng_pkg::FUNC_TICK) && (left_q != '0);

	// Hold the peak level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= stng_pkg::AMP_RESET;
		end else if (cfg_we) begin
			amp_q <= cfg_wdata;
		end
	end

	// Carry out loads and ticks on the oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			left_q  <= '0;
		end else if (q_pop) begin
			if (q_item.func == stng_pkg::FUNC_LOAD) begin
				step_q  <= q_item.step;
				phase_q <= '0;
				left_q  <= q_item.count;
			end else if (left_q != '0) begin
				phase_q <= phase_q + step_q;
				left_q  <= left_q - 1'b1;
			end
		end
	end

	// Fold the phase onto the quarter-wave table
	assign idx   = phase_q[stng_pkg::STEP_W-1 -: stng_pkg::TABLE_BITS];
	assign k_ext = {1'b0, idx[stng_pkg::TABLE_BITS-3:0]};
	assign addr  = idx[stng_pkg::TABLE_BITS-2] ?
		(stng_pkg::ADDR_W'(stng_pkg::QUARTER) - k_ext) : k_ext;

	// Stage 1: table magnitude and sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= stng_pkg::SINE_TAB[addr];
			neg_s1  <= idx[stng_pkg::TABLE_BITS-1];
			last_s1 <= (left_q == stng_pkg::CNT_W'(1));
		end
	end

	// Stage 2: scale by the peak level, truncate the magnitude, apply sign
	assign prod   = {{stng_pkg::AMP_W{1'b0}}, mag_s1} * {{stng_pkg::SINE_W{1'b0}}, amp_q};
	assign scaled = {1'b0, prod[2*stng_pkg::AMP_W-1 -: stng_pkg::AMP_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= neg_s1 ? (~scaled + 1'b1) : scaled;
			last_q   <= last_s1;
		end
	end

endmodule

// ===== rtl/core/sine_tone_note_generator_core.sv =====
// DDS tone generator. Each input word is either a note load (tuser 0: phase step and
// duration in ms) or a sample tick (tuser 1). A load clears the phase, latches the step
// and sets the sample count to floor(ms * 44100 / 1000), saturating at 2^22-1; it gives
// no output. A tick with samples left emits one signed 16-bit sample, amplitude times a
// quarter-wave table sine truncated toward zero, with tlast on the final sample of the
// note; a tick with none left gives no output. One word is accepted every clock cycle;
// only output backpressure holding the four-word queue full slows the input. A tick's
// sample passes through two front stages that compute the sample count, the queue, and
// two back stages for table lookup and the amplitude multiply before it is presented on
// the output. Write cfg_wdata (amplitude, reset 28000) only while idle.
module sine_tone_note_generator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [stng_pkg::AMP_W-1:0]      cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [47:0]                     s_tdata,  // phase_step[31:0], duration_ms[47:32]
	input  logic [0:0]                      s_tuser,  // func[0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,  // sample[15:0]
	output logic                            m_tlast
);

	logic            push;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;
	stng_pkg::item_t front_item;
	stng_pkg::item_t q_item;

	stng_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (stng_pkg::func_t'(s_tuser[0])),
		.in_step  (s_tdata[31:0]),
		.in_dur   (s_tdata[47:32]),
		.push     (push),
		.item     (front_item),
		.q_full   (q_full)
	);

	stng_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.full    (q_full),
		.pop     (q_pop),
		.rd_item (q_item),
		.empty   (q_empty)
	);

	stng_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_item     (q_item),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sample (m_tdata),
		.out_last   (m_tlast)
	);

endmodule
